/* rtl/modular_multiply_63bit_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the modular multiplier
// Shared property forms, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MODULAR_MULTIPLY_63BIT_UNIT_ASSERT_SVH
`define MODULAR_MULTIPLY_63BIT_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define MM63_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Check that cons holds in the cycle after ante
`define MM63_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

/* rtl/mm63_pkg.sv */
// ----------------------------------------------------------------------------
// Modular multiplier package
// Widths, the word carried down the cell chain, and the cell kinds.
// ----------------------------------------------------------------------------
package mm63_pkg;

   localparam int OPERAND_BITS = 63;
   // reduce a, then a double and an add cell for each multiplier bit
   localparam int STAGE_COUNT  = 3 * OPERAND_BITS;

   typedef enum logic [1:0] {
      KIND_REDUCE,
      KIND_DOUBLE,
      KIND_ADD
   } cell_kind_type;

   typedef struct packed {
      logic [OPERAND_BITS-1:0] a;    // multiplicand bits still to shift in
      logic [OPERAND_BITS-1:0] b;    // multiplier bits still to consume
      logic [OPERAND_BITS-1:0] m;    // modulus
      logic [OPERAND_BITS-1:0] rem;  // partial, then final, a mod m
      logic [OPERAND_BITS-1:0] acc;  // running product mod m
   } chain_word_type;

   // Kind of the cell at a given place in the chain
   function automatic cell_kind_type stage_kind(int k);
      cell_kind_type kind;
      if (k < OPERAND_BITS) begin
         kind = KIND_REDUCE;
      end else if (((k - OPERAND_BITS) % 2) == 0) begin
         kind = KIND_DOUBLE;
      end else begin
         kind = KIND_ADD;
      end
      return kind;
   endfunction

endpackage

/* rtl/modular_multiply_63bit_unit.sv */
// ----------------------------------------------------------------------------
// Modular multiplier, 63-bit operands
// Returns (a * b) mod m through a chain of registered modular add cells.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel req_valid/req_ready carries a, b and m; response channel
//   rsp_valid/rsp_ready carries product_mod and zero_modulus, one response
//   word per request word, in order.
//   A new request word is taken every cycle unless the skid register is full.
//   Each word runs through 189 cells: 63 that reduce a modulo m one bit at
//   a time, then a double cell and an add cell for each multiplier bit from
//   the top down, and then through the output register that drives rsp_valid.
//   A zero modulus gives product_mod of zero and zero_modulus set.
//   When the receiver stalls, one word goes into a skid register; while the
//   skid register is full the whole chain holds and req_ready is low, so the
//   throughput is one word per cycle whenever rsp_ready stays high.
//   req_ready comes from a register only, with no path from rsp_ready.
//   Reset clears every valid bit in the chain and the output stage; the
//   block takes requests as soon as reset is released.
// ----------------------------------------------------------------------------
module modular_multiply_63bit_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [mm63_pkg::OPERAND_BITS-1:0] req_a,
   input  logic [mm63_pkg::OPERAND_BITS-1:0] req_b,
   input  logic [mm63_pkg::OPERAND_BITS-1:0] req_m,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mm63_pkg::OPERAND_BITS-1:0] rsp_product_mod,
   output logic                              rsp_zero_modulus
);

   mm63_pkg::chain_word_type          stage_word  [0:mm63_pkg::STAGE_COUNT];
   logic                              stage_valid [0:mm63_pkg::STAGE_COUNT];
   logic                              pipe_enable;
   logic                              last_fire;
   logic                              last_zero;
   logic [mm63_pkg::OPERAND_BITS-1:0] last_product;

   logic                              out_valid_ff, out_valid_in;
   logic [mm63_pkg::OPERAND_BITS-1:0] out_product_ff, out_product_in;
   logic                              out_zero_ff, out_zero_in;
   logic                              skid_valid_ff, skid_valid_in;
   logic [mm63_pkg::OPERAND_BITS-1:0] skid_product_ff, skid_product_in;
   logic                              skid_zero_ff, skid_zero_in;

   // Load the request word at the head of the chain
   always_comb begin
      stage_word[0].a   = req_a;
      stage_word[0].b   = req_b;
      stage_word[0].m   = req_m;
      stage_word[0].rem = '0;
      stage_word[0].acc = '0;
      stage_valid[0]    = req_valid;
   end

   // Chain advances as one unless the skid register is full
   assign pipe_enable = !skid_valid_ff;
   assign req_ready   = pipe_enable;

   // Build the cell chain
   for (genvar k = 0; k < mm63_pkg::STAGE_COUNT; k++) begin : g_cell
      mm63_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (pipe_enable),
         .kind      (mm63_pkg::stage_kind(k)),
         .in_valid  (stage_valid[k]),
         .in_word   (stage_word[k]),
         .out_valid (stage_valid[k+1]),
         .out_word  (stage_word[k+1])
      );
   end

   // Form the result at the tail of the chain
   assign last_fire    = stage_valid[mm63_pkg::STAGE_COUNT] && pipe_enable;
   assign last_zero    = (stage_word[mm63_pkg::STAGE_COUNT].m == '0);
   assign last_product = last_zero ? '0 : stage_word[mm63_pkg::STAGE_COUNT].acc;

   // Output register with one skid entry
   always_comb begin
      out_valid_in    = out_valid_ff;
      out_product_in  = out_product_ff;
      out_zero_in     = out_zero_ff;
      skid_valid_in   = skid_valid_ff;
      skid_product_in = skid_product_ff;
      skid_zero_in    = skid_zero_ff;
      // drain: move the skid word up or empty the output
      if (out_valid_ff && rsp_ready) begin
         if (skid_valid_ff) begin
            out_product_in = skid_product_ff;
            out_zero_in    = skid_zero_ff;
            skid_valid_in  = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
      // fill: park in skid if the output is stalled
      if (last_fire) begin
         if (out_valid_ff && !rsp_ready) begin
            skid_valid_in   = 1'b1;
            skid_product_in = last_product;
            skid_zero_in    = last_zero;
         end else begin
            out_valid_in   = 1'b1;
            out_product_in = last_product;
            out_zero_in    = last_zero;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_product_ff  <= out_product_in;
      out_zero_ff     <= out_zero_in;
      skid_product_ff <= skid_product_in;
      skid_zero_ff    <= skid_zero_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_product_mod  = out_product_ff;
   assign rsp_zero_modulus = out_zero_ff;

`include "modular_multiply_63bit_unit_assert.svh"

   // skid only fills behind a held output word
   `MM63_ASSERT_IMP(a_skid_behind_out, skid_valid_ff, out_valid_ff)
   // a parked word is kept until the output drains
   `MM63_ASSERT_NEXT(a_skid_kept, skid_valid_ff && !rsp_ready, skid_valid_ff)
   // an error response always carries a zero product
   `MM63_ASSERT_IMP(a_zero_result, out_valid_ff && out_zero_ff, out_product_ff == '0)

endmodule

/* rtl/mm63_cell.sv */
// ----------------------------------------------------------------------------
// Modular multiplier chain cell
// One modular add step (x + y + cin) mod m, registered, per chain position.
// ----------------------------------------------------------------------------
module mm63_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  mm63_pkg::cell_kind_type kind,
   input  logic                    in_valid,
   input  mm63_pkg::chain_word_type in_word,
   output logic                    out_valid,
   output mm63_pkg::chain_word_type out_word
);

   logic                              valid_ff;
   mm63_pkg::chain_word_type          word_ff;
   mm63_pkg::chain_word_type          word_in;
   logic [mm63_pkg::OPERAND_BITS-1:0] x;
   logic [mm63_pkg::OPERAND_BITS-1:0] y;
   logic                              cin;
   logic [mm63_pkg::OPERAND_BITS:0]   sum;
   logic [mm63_pkg::OPERAND_BITS:0]   reduced;

   // Pick operands for this cell's step
   always_comb begin
      x   = in_word.acc;
      y   = in_word.acc;
      cin = 1'b0;
      case (kind)
         mm63_pkg::KIND_REDUCE: begin
            x   = in_word.rem;
            y   = in_word.rem;
            cin = in_word.a[mm63_pkg::OPERAND_BITS-1];
         end
         mm63_pkg::KIND_DOUBLE: begin
            x = in_word.acc;
            y = in_word.acc;
         end
         mm63_pkg::KIND_ADD: begin
            x = in_word.acc;
            y = in_word.b[mm63_pkg::OPERAND_BITS-1] ? in_word.rem : '0;
         end
         default: begin
            x = in_word.acc;
            y = in_word.acc;
         end
      endcase
   end

   // Add, then subtract m once if the sum reached it
   always_comb begin
      sum     = {1'b0, x} + {1'b0, y} + {{mm63_pkg::OPERAND_BITS{1'b0}}, cin};
      reduced = (sum >= {1'b0, in_word.m}) ? (sum - {1'b0, in_word.m}) : sum;
   end

   // Update the field this cell owns and advance the consumed operand
   always_comb begin
      word_in = in_word;
      case (kind)
         mm63_pkg::KIND_REDUCE: begin
            word_in.rem = reduced[mm63_pkg::OPERAND_BITS-1:0];
            word_in.a   = {in_word.a[mm63_pkg::OPERAND_BITS-2:0], 1'b0};
         end
         mm63_pkg::KIND_DOUBLE: begin
            word_in.acc = reduced[mm63_pkg::OPERAND_BITS-1:0];
         end
         mm63_pkg::KIND_ADD: begin
            word_in.acc = reduced[mm63_pkg::OPERAND_BITS-1:0];
            word_in.b   = {in_word.b[mm63_pkg::OPERAND_BITS-2:0], 1'b0};
         end
         default: begin
            word_in = in_word;
         end
      endcase
   end

   // Hold while the chain is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

/* bench/tb_modular_multiply_63bit_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the 63-bit modular multiplier
// Sends operand words (a, b, m) and checks every response word in order
// against an exact wide product reduced modulo m. Covers operand corners,
// zero and unit moduli, random streams under several idle and stall mixes,
// a long receiver hold-off that fills the chain, and drained pauses.
// ----------------------------------------------------------------------------
module tb_modular_multiply_63bit_unit;

   localparam int W            = mm63_pkg::OPERAND_BITS;
   localparam int WATCHDOG_MAX = 4000;
   localparam int TAIL_CYCLES  = 200;

   typedef logic [W-1:0] operand_type;

   typedef struct {
      operand_type product_mod;
      logic        zero_modulus;
   } product_result_type;

   localparam operand_type OPERAND_MAX = {W{1'b1}};

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   operand_type req_a;
   operand_type req_b;
   operand_type req_m;
   logic        rsp_valid;
   logic        rsp_ready;
   operand_type rsp_product_mod;
   logic        rsp_zero_modulus;

   product_result_type expected_products[$];

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_off_request   = 0;
   int error_count        = 0;
   int sent_count         = 0;
   int checked_count      = 0;
   int zero_modulus_count = 0;
   int input_stall_cycles = 0;

   modular_multiply_63bit_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_a            (req_a),
      .req_b            (req_b),
      .req_m            (req_m),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_product_mod  (rsp_product_mod),
      .rsp_zero_modulus (rsp_zero_modulus)
   );

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Exact (a * b) mod m from the full-width product
   function automatic product_result_type predict_product(operand_type a, operand_type b,
                                                          operand_type m);
      product_result_type res;
      logic [2*W-1:0]     wide;
      wide = {{W{1'b0}}, a} * {{W{1'b0}}, b};
      if (m == '0) begin
         res.product_mod  = '0;
         res.zero_modulus = 1'b1;
      end else begin
         wide             = wide % {{W{1'b0}}, m};
         res.product_mod  = wide[W-1:0];
         res.zero_modulus = 1'b0;
      end
      return res;
   endfunction

   // Operand with a random bit length, near-max or tiny value now and then
   function automatic operand_type random_operand();
      logic [63:0] raw;
      operand_type value;
      int          span;
      raw   = {$urandom, $urandom};
      value = raw[W-1:0];
      case ($urandom_range(9))
         4, 5, 6: begin
            span  = $urandom_range(W, 1);
            value = value >> (W - span);
         end
         7: value = value | (operand_type'(1) << (W - 1));
         8: value = OPERAND_MAX - operand_type'($urandom_range(3));
         9: value = operand_type'($urandom_range(3));
         default: ;
      endcase
      return value;
   endfunction

   // Modulus: mostly random lengths, with zero, one and powers of two mixed in
   function automatic operand_type random_modulus();
      operand_type value;
      case ($urandom_range(49))
         0: value = '0;
         1: value = operand_type'(1);
         2: value = operand_type'(1) << $urandom_range(W - 1);
         default: value = random_operand();
      endcase
      return value;
   endfunction

   // Offer one operand word and record its expected result on acceptance
   task automatic offer_operands(operand_type a, operand_type b, operand_type m);
      while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_a     <= a;
      req_b     <= b;
      req_m     <= m;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_products.push_back(predict_product(a, b, m));
      sent_count++;
   endtask

   // Drop valid and hold until every expected word has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_products.size() != 0) @(posedge clock);
   endtask

   task automatic run_random_words(int count, int idle_pct, int stall_pct);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (count) offer_operands(random_operand(), random_operand(), random_modulus());
      wait_for_results();
   endtask

   // Operand extremes, zero and unit modulus, a at or above m
   task automatic test_directed_corners();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      offer_operands('0, '0, OPERAND_MAX);
      offer_operands(OPERAND_MAX, OPERAND_MAX, OPERAND_MAX);
      offer_operands(OPERAND_MAX, OPERAND_MAX, OPERAND_MAX - 1);
      offer_operands(OPERAND_MAX, OPERAND_MAX, '0);
      offer_operands('0, '0, '0);
      offer_operands(operand_type'(1), operand_type'(1), '0);
      offer_operands(operand_type'(5), operand_type'(7), operand_type'(1));
      offer_operands(OPERAND_MAX, OPERAND_MAX, operand_type'(1));
      offer_operands(OPERAND_MAX, operand_type'(1), OPERAND_MAX - 1);
      offer_operands(operand_type'(1), OPERAND_MAX, operand_type'(2));
      offer_operands(OPERAND_MAX, OPERAND_MAX, operand_type'(1) << (W - 1));
      offer_operands(operand_type'(1) << (W - 1), operand_type'(1) << (W - 1), OPERAND_MAX);
      offer_operands(operand_type'(123456789), operand_type'(987654321),
                     operand_type'(1000000007));
      offer_operands(OPERAND_MAX, '0, operand_type'(3));
      offer_operands('0, OPERAND_MAX, operand_type'(3));
      offer_operands(operand_type'(2), operand_type'(3), OPERAND_MAX);
      offer_operands(operand_type'(1000), operand_type'(5), operand_type'(1000));
      offer_operands(OPERAND_MAX - 1, OPERAND_MAX - 1, OPERAND_MAX);
      offer_operands(operand_type'({(W+1)/2{2'b01}}), operand_type'({(W+1)/2{2'b10}}),
                     (operand_type'(1) << (W - 2)) | operand_type'(1));
      offer_operands(operand_type'({(W+1)/2{2'b10}}), operand_type'({(W+1)/2{2'b01}}),
                     OPERAND_MAX >> 1);
      wait_for_results();
   endtask

   task automatic test_streaming_no_idle();
      run_random_words(450, 0, 0);
   endtask

   task automatic test_sparse_sender();
      run_random_words(350, 78, 0);
   endtask

   task automatic test_slow_receiver();
      run_random_words(450, 0, 78);
   endtask

   task automatic test_light_idle_both();
      run_random_words(400, 13, 13);
   endtask

   // Hold the receiver off long enough that the chain fills and stalls input
   task automatic test_fill_under_hold_off();
      receiver_stall_pct = 0;
      sender_idle_pct    = 0;
      hold_off_request   = 600;
      repeat (260) offer_operands(random_operand(), random_operand(), random_modulus());
      wait_for_results();
   endtask

   // Short bursts, each drained completely before the next
   task automatic test_pause_until_drained();
      repeat (3) run_random_words(20, 0, 30);
   endtask

   // Receiver: random stalls, or a counted hold-off when one is requested
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request > 0) begin
            hold_left        = hold_off_request;
            hold_off_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // Compare each response word with the oldest expectation
   always @(posedge clock) begin : check_results
      product_result_type want;
      if (!reset && req_valid && !req_ready) begin
         input_stall_cycles++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_products.size() == 0) begin
            $error("response word with no request outstanding: product_mod %0h",
                   rsp_product_mod);
            error_count++;
         end else begin
            want = expected_products.pop_front();
            checked_count++;
            if (want.zero_modulus) zero_modulus_count++;
            if (rsp_product_mod !== want.product_mod) begin
               $error("product_mod: expected %0h, actual %0h",
                      want.product_mod, rsp_product_mod);
               error_count++;
            end
            if (rsp_zero_modulus !== want.zero_modulus) begin
               $error("zero_modulus: expected %0b, actual %0b",
                      want.zero_modulus, rsp_zero_modulus);
               error_count++;
            end
         end
      end
   end

   // Abort when no word moves on either channel for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_MAX) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_MAX);
      $display("tb: failure");
      $finish;
   end

   // Reset, then run each test in turn
   initial begin : main_sequence
      reset     = 1'b1;
      req_valid = 1'b0;
      req_a     = '0;
      req_b     = '0;
      req_m     = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_corners();
      test_streaming_no_idle();
      test_sparse_sender();
      test_slow_receiver();
      test_light_idle_both();
      test_fill_under_hold_off();
      test_pause_until_drained();

      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d operand words, %0d responses checked, %0d with zero modulus",
               sent_count, checked_count, zero_modulus_count);
      $display("request side held off for %0d cycles by a full chain or stalls",
               input_stall_cycles);
      if (error_count == 0 && expected_products.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
